FILE: src/gbe_pkg.sv
// Shared widths, request codes and status codes for the gap buffer engine.
package gbe_pkg;

  localparam int REQ_W  = 3;
  localparam int CHAR_W = 8;
  localparam int POS_W  = 11;
  localparam int STAT_W = 3;

  localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_BACKSPACE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MOVE      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_AT_START = 3'd2;
  localparam logic [STAT_W-1:0] ST_AT_END   = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

endpackage

FILE: src/gap_buffer_engine.sv
// Gap buffer engine: byte store, gap registers and the request sequencer.
// A request is registered and run in EXEC. Insert, backspace, delete, a move
// that is refused or stays put, unknown requests and refused reads go to DONE;
// a read goes via READ; a move via MOVE copies the bytes between old and new gap.
// One request at a time, the next taken the cycle after the result is loaded.
// Reset empties the text (gap at 0, full-size gap); store contents stay undefined.
module gap_buffer_engine #(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gbe_pkg::REQ_W-1:0]   req_type,
  input  logic [gbe_pkg::CHAR_W-1:0]  char_in,
  input  logic [gbe_pkg::POS_W-1:0]   position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gbe_pkg::STAT_W-1:0]  status,
  output logic [gbe_pkg::CHAR_W-1:0]  char_out,
  output logic [gbe_pkg::POS_W-1:0]   cursor_offset,
  output logic [gbe_pkg::POS_W-1:0]   text_length
);
  import gbe_pkg::*;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MOVE = 5'b00100,
    S_READ = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  gap_begin;
  logic [CNT_W-1:0]  gap_size;
  logic [CNT_W-1:0]  text_count;

  logic [REQ_W-1:0]  req_r;
  logic [CHAR_W-1:0] char_r;
  logic [W-1:0]      pos_r;

  logic [STAT_W-1:0] res_status;
  logic [CHAR_W-1:0] res_char;

  logic [CNT_W-1:0]  remaining;
  logic [CNT_W-1:0]  src;
  logic [CNT_W-1:0]  dst;
  logic              down;
  logic              pend;
  logic [CNT_W-1:0]  pend_dst;

  logic [CHAR_W-1:0] mem [CAPACITY];
  logic [CHAR_W-1:0] mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic [W-1:0]      gb_w;
  logic [W-1:0]      tc_w;
  logic [CNT_W-1:0]  pos_cnt;
  logic [CNT_W:0]    phys;
  logic              in_take;
  logic              out_load;

  assign gb_w     = W'(gap_begin);
  assign tc_w     = W'(text_count);
  assign pos_cnt  = pos_r[CNT_W-1:0];
  assign phys     = (pos_r < gb_w) ? {1'b0, pos_cnt} : {1'b0, pos_cnt} + {1'b0, gap_size};
  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_dst[ADDR_W-1:0];
    mem_wdata = mem_q;
    mem_raddr = src[ADDR_W-1:0];
    if (state == S_EXEC) begin
      mem_waddr = gap_begin[ADDR_W-1:0];
      mem_wdata = char_r;
      mem_raddr = phys[ADDR_W-1:0];
      mem_we    = (req_r == REQ_INSERT) && (gap_size != '0);
    end else if (state == S_MOVE) begin
      mem_we = pend;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      gap_begin  <= '0;
      gap_size   <= CAP_CNT;
      text_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            req_r  <= req_type;
            char_r <= char_in;
            pos_r  <= W'(position);
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_char <= '0;
          unique case (req_r)
            REQ_INSERT: begin
              state <= S_DONE;
              if (gap_size == '0) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_OK;
                gap_begin  <= gap_begin + 1'b1;
                gap_size   <= gap_size - 1'b1;
                text_count <= text_count + 1'b1;
              end
            end
            REQ_BACKSPACE: begin
              state <= S_DONE;
              if (gap_begin == '0) begin
                res_status <= ST_AT_START;
              end else begin
                res_status <= ST_OK;
                gap_begin  <= gap_begin - 1'b1;
                gap_size   <= gap_size + 1'b1;
                text_count <= text_count - 1'b1;
              end
            end
            REQ_DELETE: begin
              state <= S_DONE;
              if (gap_begin >= text_count) begin
                res_status <= ST_AT_END;
              end else begin
                res_status <= ST_OK;
                gap_size   <= gap_size + 1'b1;
                text_count <= text_count - 1'b1;
              end
            end
            REQ_MOVE: begin
              priority if (pos_r > tc_w) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else if (pos_r > gb_w) begin
                res_status <= ST_OK;
                down       <= 1'b1;
                remaining  <= pos_cnt - gap_begin;
                src        <= gap_begin + gap_size;
                dst        <= gap_begin;
                pend       <= 1'b0;
                state      <= S_MOVE;
              end else if (pos_r < gb_w) begin
                res_status <= ST_OK;
                down       <= 1'b0;
                remaining  <= gap_begin - pos_cnt;
                src        <= gap_begin - 1'b1;
                dst        <= gap_begin - 1'b1 + gap_size;
                pend       <= 1'b0;
                state      <= S_MOVE;
              end else begin
                res_status <= ST_OK;
                state      <= S_DONE;
              end
            end
            REQ_READ: begin
              if (pos_r >= tc_w) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_READ;
              end
            end
            default: begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          endcase
        end
        S_MOVE: begin
          if (remaining != '0) begin
            pend      <= 1'b1;
            pend_dst  <= dst;
            remaining <= remaining - 1'b1;
            src       <= down ? src + 1'b1 : src - 1'b1;
            dst       <= down ? dst + 1'b1 : dst - 1'b1;
          end else begin
            pend      <= 1'b0;
            gap_begin <= pos_cnt;
            state     <= S_DONE;
          end
        end
        S_READ: begin
          res_char <= mem_q;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      char_out      <= res_char;
      cursor_offset <= gb_w[POS_W-1:0];
      text_length   <= tc_w[POS_W-1:0];
    end
  end

  a_size_sum: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, text_count} + {1'b0, gap_size}) == {1'b0, CAP_CNT})
    else $error("text count plus gap size differs from capacity");

  a_gap_in_text: assert property (@(posedge clk) disable iff (rst)
    gap_begin <= text_count)
    else $error("gap start beyond text length");

  a_move_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) && (remaining == '0) |=> (state == S_DONE) && !pend)
    else $error("gap move did not finish");

  a_write_only_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_EXEC) || (state == S_MOVE))
    else $error("store written outside a request");

endmodule
